[sv/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and constants for the cursor sequence list.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 3'd0,
    CMD_ADVANCE = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_ATTACH  = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

endpackage

[sv/csl_cell.sv]
// ----------------------------------------------------------------------------
// csl_cell
// One list entry: holds a word; loads a neighbor's word or the inserted word.
// ----------------------------------------------------------------------------
module csl_cell import csl_pkg::*; #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned POS_W      = 6,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  cell_op_e              op_i,
  input  logic [POS_W-1:0]      pos_i,
  input  logic [WORD_WIDTH-1:0] word_i,
  input  logic [WORD_WIDTH-1:0] lower_i,
  input  logic [WORD_WIDTH-1:0] upper_i,
  output logic [WORD_WIDTH-1:0] word_q_o,
  output logic [WORD_WIDTH-1:0] word_d_o
);

  localparam logic [POS_W-1:0] Idx = POS_W'(CELL_IDX);

  logic [WORD_WIDTH-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (op_i)
      CELL_INSERT: begin
        if (Idx > pos_i) begin
          word_d = lower_i;
        end else if (Idx == pos_i) begin
          word_d = word_i;
        end
      end
      CELL_REMOVE: begin
        if (Idx >= pos_i) begin
          word_d = upper_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_q_o = word_q;
  assign word_d_o = word_d;

endmodule

[sv/cursor_sequence_list_core.sv]
// ----------------------------------------------------------------------------
// cursor_sequence_list_core
// Ordered word list with a cursor, held in a row of shifting cells.
//
//   channel | signals                                   | dir
//   in      | in_valid_i, in_ready_o, command_i,        | in
//           | entry_word_i                              |
//   out     | out_valid_o, out_ready_i, current_word_o, | out
//           | has_current_o, item_count_o, error_flag_o |
//
// one command per cycle: the cells at and above the insert or remove point
// shift in the accept cycle; the result beat is registered at that same edge.
// a new beat is taken while the result register is empty or being drained.
// reset clears count, cursor and the result valid flag; cell words stay unset.
// a stalled output holds the input off until the result beat is taken.
// ----------------------------------------------------------------------------
module cursor_sequence_list_core import csl_pkg::*; #(
  parameter int unsigned LIST_CAPACITY = 32,
  parameter int unsigned WORD_WIDTH    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [FIELD_W-1:0] entry_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FIELD_W-1:0] current_word_o,
  output logic               has_current_o,
  output logic [COUNT_W-1:0] item_count_o,
  output logic               error_flag_o
);

  localparam int unsigned PosW   = $clog2(LIST_CAPACITY + 1);
  localparam int unsigned IdxW   = $clog2(LIST_CAPACITY);
  localparam int unsigned InBits = (WORD_WIDTH < FIELD_W) ? WORD_WIDTH : FIELD_W;
  localparam int unsigned CntBits = (PosW < COUNT_W) ? PosW : COUNT_W;
  localparam logic [PosW-1:0] Cap = PosW'(LIST_CAPACITY);

  logic [PosW-1:0] cnt_q, cnt_d, cur_q, cur_d;
  logic            out_valid_q;
  logic            has_q, err_q, err_d;
  logic [FIELD_W-1:0] out_word_q, out_word_d;
  logic [PosW-1:0]    out_cnt_q;

  cell_op_e              cell_op;
  logic [PosW-1:0]       cell_pos;
  logic [WORD_WIDTH-1:0] entry_w;
  logic [WORD_WIDTH-1:0] cell_q [LIST_CAPACITY];
  logic [WORD_WIDTH-1:0] cell_d [LIST_CAPACITY];

  logic in_acc, present, full, has_d;
  cmd_e cmd;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(command_i);
  assign present    = cur_q < cnt_q;
  assign full       = cnt_q >= Cap;

  always_comb begin
    entry_w = '0;
    for (int i = 0; i < InBits; i++) begin
      entry_w[i] = entry_word_i[i];
    end
  end

  // command decode
  always_comb begin
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    err_d    = 1'b0;
    cell_op  = CELL_HOLD;
    cell_pos = cur_q;
    if (in_acc) begin
      case (cmd)
        CMD_START: cur_d = '0;
        CMD_ADVANCE: begin
          if (!present) begin
            err_d = 1'b1;
          end else begin
            cur_d = cur_q + PosW'(1);
          end
        end
        CMD_INSERT: begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            cell_op  = CELL_INSERT;
            cell_pos = present ? cur_q : '0;
            cur_d    = cell_pos;
            cnt_d    = cnt_q + PosW'(1);
          end
        end
        CMD_ATTACH: begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            cell_op  = CELL_INSERT;
            cell_pos = present ? cur_q + PosW'(1) : cnt_q;
            cur_d    = cell_pos;
            cnt_d    = cnt_q + PosW'(1);
          end
        end
        CMD_REMOVE: begin
          if (!present) begin
            err_d = 1'b1;
          end else begin
            cell_op = CELL_REMOVE;
            cnt_d   = cnt_q - PosW'(1);
          end
        end
        default: cnt_d = cnt_q;
      endcase
    end
  end

  for (genvar k = 0; k < LIST_CAPACITY; k++) begin : g_cell
    logic [WORD_WIDTH-1:0] lower, upper;
    if (k == 0) begin : g_first
      assign lower = cell_q[k];
    end else begin : g_mid_lo
      assign lower = cell_q[k-1];
    end
    if (k == LIST_CAPACITY - 1) begin : g_last
      assign upper = cell_q[k];
    end else begin : g_mid_hi
      assign upper = cell_q[k+1];
    end
    csl_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .POS_W      (PosW),
      .CELL_IDX   (k)
    ) u_cell (
      .clk_i    (clk_i),
      .op_i     (cell_op),
      .pos_i    (cell_pos),
      .word_i   (entry_w),
      .lower_i  (lower),
      .upper_i  (upper),
      .word_q_o (cell_q[k]),
      .word_d_o (cell_d[k])
    );
  end

  // word at the new cursor
  assign has_d = cur_d < cnt_d;

  always_comb begin
    logic [WORD_WIDTH-1:0] sel;
    sel        = cell_d[cur_d[IdxW-1:0]];
    out_word_d = '0;
    if (has_d) begin
      for (int i = 0; i < InBits; i++) begin
        out_word_d[i] = sel[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_word_q <= out_word_d;
      has_q      <= has_d;
      err_q      <= err_d;
      out_cnt_q  <= cnt_d;
    end
  end

  always_comb begin
    item_count_o = '0;
    for (int i = 0; i < CntBits; i++) begin
      item_count_o[i] = out_cnt_q[i];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign current_word_o = out_word_q;
  assign has_current_o  = has_q;
  assign error_flag_o   = err_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= cnt_q)
    else $error("cursor beyond count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Cap)
    else $error("count beyond capacity");

  a_refused_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && err_d |=> cnt_q == $past(cnt_q))
    else $error("refused command changed count");

  a_remove_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd == CMD_REMOVE && !err_d |=> cnt_q == $past(cnt_q) - PosW'(1))
    else $error("remove did not drop one word");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> has_q == (cur_q < cnt_q))
    else $error("reported cursor state differs from held state");

endmodule

[verif/cursor_sequence_list_checker.sv]
// ----------------------------------------------------------------------------
// cursor_sequence_list_checker
// Watches both channels of the cursor sequence list. Each accepted command is
// run through a local model of the list (its own copy of the word cells, the
// count and the cursor), and the resulting view is queued. Each result beat is
// compared field by field with the oldest queued view.
// ----------------------------------------------------------------------------
module cursor_sequence_list_checker import csl_pkg::*; #(
  parameter int unsigned LIST_CAPACITY = 32,
  parameter int unsigned WORD_WIDTH    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [FIELD_W-1:0] entry_word_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [FIELD_W-1:0] current_word_o,
  input  logic               has_current_o,
  input  logic [COUNT_W-1:0] item_count_o,
  input  logic               error_flag_o,
  output int                 mismatches_o,
  output int                 views_due_o,
  output int                 views_checked_o,
  output int                 refusals_o,
  output int                 peak_fill_o
);

  typedef struct packed {
    logic [FIELD_W-1:0] word;
    logic               present;
    logic [COUNT_W-1:0] count;
    logic               refused;
  } list_view_t;

  logic [WORD_WIDTH-1:0] cell_words [LIST_CAPACITY];
  int                    held;
  int                    cursor;
  list_view_t            views_due [$];
  int                    mismatch_total;
  int                    checked_total;
  int                    refusal_total;
  int                    peak_total;

  initial begin
    mismatches_o    = 0;
    views_due_o     = 0;
    views_checked_o = 0;
    refusals_o      = 0;
    peak_fill_o     = 0;
    mismatch_total  = 0;
    checked_total   = 0;
    refusal_total   = 0;
    peak_total      = 0;
    held            = 0;
    cursor          = 0;
  end

  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] want,
                                 input logic [FIELD_W-1:0] got);
    $display("mismatch on %s: expected %h, got %h", what, want, got);
    mismatch_total++;
  endtask

  // updates the list by one command and returns what the block should show
  task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                    input logic [FIELD_W-1:0] word,
                                    output list_view_t view);
    logic present;
    logic full;
    int   i;
    present = cursor < held;
    full    = held >= LIST_CAPACITY;
    view    = '0;
    case (cmd)
      CMD_START: begin
        cursor = 0;
      end
      CMD_ADVANCE: begin
        if (!present) view.refused = 1'b1;
        else cursor++;
      end
      CMD_INSERT: begin
        if (full) begin
          view.refused = 1'b1;
        end else begin
          if (!present) cursor = 0;
          for (i = held; i > cursor; i--) cell_words[i] = cell_words[i-1];
          cell_words[cursor] = word[WORD_WIDTH-1:0];
          held++;
        end
      end
      CMD_ATTACH: begin
        if (full) begin
          view.refused = 1'b1;
        end else begin
          if (!present) begin
            cell_words[held] = word[WORD_WIDTH-1:0];
            cursor = held;
          end else begin
            for (i = held; i > cursor + 1; i--) cell_words[i] = cell_words[i-1];
            cell_words[cursor+1] = word[WORD_WIDTH-1:0];
            cursor++;
          end
          held++;
        end
      end
      CMD_REMOVE: begin
        if (!present) begin
          view.refused = 1'b1;
        end else begin
          for (i = cursor + 1; i < held; i++) cell_words[i-1] = cell_words[i];
          held--;
        end
      end
      default: ;
    endcase
    view.present = cursor < held;
    view.word    = view.present ? FIELD_W'(cell_words[cursor]) : '0;
    view.count   = COUNT_W'(held);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_view_t got_view;
    list_view_t new_view;
    if (!rst_ni) begin
      held   = 0;
      cursor = 0;
      views_due.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (views_due.size() == 0) begin
          report_mismatch("unexpected result beat", '0, current_word_o);
        end else begin
          got_view = views_due.pop_front();
          if (current_word_o !== got_view.word)
            report_mismatch("current_word", got_view.word, current_word_o);
          if (has_current_o !== got_view.present)
            report_mismatch("has_current", FIELD_W'(got_view.present), FIELD_W'(has_current_o));
          if (item_count_o !== got_view.count)
            report_mismatch("item_count", FIELD_W'(got_view.count), FIELD_W'(item_count_o));
          if (error_flag_o !== got_view.refused)
            report_mismatch("error_flag", FIELD_W'(got_view.refused), FIELD_W'(error_flag_o));
          checked_total++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        apply_list_command(command_i, entry_word_i, new_view);
        views_due.push_back(new_view);
        if (new_view.refused) refusal_total++;
        if (held > peak_total) peak_total = held;
      end
    end
    mismatches_o    <= mismatch_total;
    views_due_o     <= views_due.size();
    views_checked_o <= checked_total;
    refusals_o      <= refusal_total;
    peak_fill_o     <= peak_total;
  end

endmodule

[verif/cursor_sequence_list_core_tb.sv]
// ----------------------------------------------------------------------------
// cursor_sequence_list_core_tb
// Drives commands into the cursor sequence list and gives the verdict.
// A short directed run covers the empty list, moving past the end, insert and
// attach with and without a current word, removing the front and the last
// word, and the unused command codes. Random windows then grow the list to
// full, shrink it to empty and mix freely, under three idle mixes and one
// long output stall. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module cursor_sequence_list_core_tb;
  import csl_pkg::*;

  localparam int unsigned     CAPACITY       = 32;
  localparam int              WATCHDOG_LIMIT = 1000;
  localparam int              HOLD_CYCLES    = 60;
  localparam int              HOLD_AFTER     = 80;
  localparam logic [CMD_W-1:0] CMD_SPARE_A   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B   = 3'd7;

  typedef enum int {MIX_GROW, MIX_ANY, MIX_SHRINK} mix_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CMD_W-1:0]   command_i = CMD_QUERY;
  logic [FIELD_W-1:0] entry_word_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [FIELD_W-1:0] current_word_o;
  logic               has_current_o;
  logic [COUNT_W-1:0] item_count_o;
  logic               error_flag_o;

  int mismatches;
  int views_due;
  int views_checked;
  int refusals;
  int peak_fill;
  int send_idle = 0;
  int recv_idle = 0;
  int commands_sent = 0;
  int idle_run = 0;

  always #1 clk_i = ~clk_i;

  cursor_sequence_list_core #(
    .LIST_CAPACITY(CAPACITY),
    .WORD_WIDTH   (FIELD_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .entry_word_i  (entry_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .current_word_o(current_word_o),
    .has_current_o (has_current_o),
    .item_count_o  (item_count_o),
    .error_flag_o  (error_flag_o)
  );

  cursor_sequence_list_checker #(
    .LIST_CAPACITY(CAPACITY),
    .WORD_WIDTH   (FIELD_W)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .entry_word_i   (entry_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .current_word_o (current_word_o),
    .has_current_o  (has_current_o),
    .item_count_o   (item_count_o),
    .error_flag_o   (error_flag_o),
    .mismatches_o   (mismatches),
    .views_due_o    (views_due),
    .views_checked_o(views_checked),
    .refusals_o     (refusals),
    .peak_fill_o    (peak_fill)
  );

  // result side: random stalls plus one long hold-off once enough beats passed
  initial begin
    int  out_beats;
    bit  hold_done;
    out_beats = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) out_beats++;
      if (!hold_done && out_beats >= HOLD_AFTER) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_run);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] word);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    entry_word_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    commands_sent++;
  endtask

  function automatic logic [FIELD_W-1:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input mix_e mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW: begin
        if (r < 40) return CMD_INSERT;
        if (r < 80) return CMD_ATTACH;
        if (r < 88) return CMD_ADVANCE;
        if (r < 94) return CMD_START;
        return CMD_QUERY;
      end
      MIX_SHRINK: begin
        if (r < 50) return CMD_REMOVE;
        if (r < 65) return CMD_START;
        if (r < 80) return CMD_ADVANCE;
        if (r < 90) return CMD_INSERT;
        return CMD_W'($urandom_range(7));
      end
      default: return CMD_W'($urandom_range(7));
    endcase
  endfunction

  initial begin
    mix_e window_mix [4];
    window_mix = '{MIX_GROW, MIX_ANY, MIX_SHRINK, MIX_ANY};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 21;
    recv_idle = 49;

    // empty list, refusals, moving past the end, appends and removes
    offer_command(CMD_QUERY, '0);
    offer_command(CMD_ADVANCE, $urandom);
    offer_command(CMD_REMOVE, $urandom);
    offer_command(CMD_INSERT, '0);
    offer_command(CMD_ATTACH, '1);
    offer_command(CMD_ADVANCE, '0);
    offer_command(CMD_ADVANCE, '0);
    offer_command(CMD_ATTACH, 32'h8000_0001);
    offer_command(CMD_REMOVE, '0);
    offer_command(CMD_INSERT, 32'h7fff_fffe);
    offer_command(CMD_START, '1);
    offer_command(CMD_ADVANCE, '1);
    offer_command(CMD_INSERT, 32'ha5a5_5a5a);
    offer_command(CMD_ATTACH, 32'h5a5a_a5a5);
    offer_command(CMD_SPARE_A, '1);
    offer_command(CMD_SPARE_B, '1);
    offer_command(CMD_START, '0);
    offer_command(CMD_REMOVE, '0);
    repeat (5) offer_command(CMD_REMOVE, '0);
    offer_command(CMD_QUERY, '1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 21; recv_idle = 49; end
        1: begin send_idle = 49; recv_idle = 21; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int w = 0; w < 4; w++) begin
        repeat (50) offer_command(pick_command(window_mix[w]), pick_word());
      end
    end
    in_valid_i <= 1'b0;

    while (views_due != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d commands under three idle mixes and one long output stall, %0d checked",
             commands_sent, views_checked);
    $display("%0d commands refused, list reached %0d of %0d entries",
             refusals, peak_fill, CAPACITY);
    if (mismatches == 0 && views_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
